// ===== hdl/smdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smdu_pkg;
    localparam int WordBits   = 16;
    localparam int FieldLanes = 4;
    localparam int DivSteps   = WordBits;

    typedef logic [WordBits-1:0] word_t;

    typedef enum logic
    {
        FUNC_MUL = 1'b0,
        FUNC_DIV = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [0:0] func;
        logic [0:0] vector_mode;
        word_t      left_0;
        word_t      left_1;
        word_t      left_2;
        word_t      left_3;
        word_t      right_0;
        word_t      right_1;
        word_t      right_2;
        word_t      right_3;
    } in_item_t;

    typedef struct packed
    {
        word_t      high_0;
        word_t      high_1;
        word_t      high_2;
        word_t      high_3;
        word_t      low_0;
        word_t      low_1;
        word_t      low_2;
        word_t      low_3;
        logic [0:0] zero_hit;
        logic [0:0] divide_fault;
    } out_item_t;

    // per-lane status passed to the merge stage
    typedef struct packed
    {
        logic active;
        logic is_div;
        logic zero;
        logic div_zero;
    } lane_flags_t;
endpackage
`default_nettype wire

// ===== hdl/smdu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smdu_in_if;
    logic               valid;
    logic               ready;
    smdu_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface smdu_out_if;
    logic                valid;
    logic                ready;
    smdu_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/smdu_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One lane: pipelined multiply and restoring divide, one quotient bit per stage.
// Stage 0 registers inputs, stages 1..16 divide steps (multiply result rides along).
module smdu_lane
(
    input  wire logic                   clk,
    input  wire logic                   advance,
    input  wire logic                   active,
    input  wire logic                   is_div,
    input  wire smdu_pkg::word_t        left,
    input  wire smdu_pkg::word_t        right,
    output smdu_pkg::word_t             high,
    output smdu_pkg::word_t             low,
    output smdu_pkg::lane_flags_t       flags
);
    localparam int W = smdu_pkg::WordBits;
    localparam int S = smdu_pkg::DivSteps;

    logic [2*W-1:0]             prod_reg   [S+1];
    smdu_pkg::word_t            quo_reg    [S+1];
    logic [W:0]                 rem_reg    [S+1];
    smdu_pkg::word_t            dvd_reg    [S+1];
    smdu_pkg::word_t            dvs_reg    [S+1];
    logic                       act_reg    [S+1];
    logic                       div_reg    [S+1];

    logic [W:0]                 trial      [S];
    logic [W+1:0]               diff       [S];

    always_comb
    begin
        for (int i = 0; i < S; i++)
        begin
            trial[i] = {rem_reg[i][W-1:0], dvd_reg[i][W-1-i]};
            diff[i]  = {1'b0, trial[i]} - {2'b00, dvs_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg[0] <= left * right;
            quo_reg[0]  <= '0;
            rem_reg[0]  <= '0;
            dvd_reg[0]  <= left;
            dvs_reg[0]  <= right;
            act_reg[0]  <= active;
            div_reg[0]  <= is_div;
            for (int i = 0; i < S; i++)
            begin
                prod_reg[i+1] <= prod_reg[i];
                dvd_reg[i+1]  <= dvd_reg[i];
                dvs_reg[i+1]  <= dvs_reg[i];
                act_reg[i+1]  <= act_reg[i];
                div_reg[i+1]  <= div_reg[i];
                if (!diff[i][W+1])
                begin
                    rem_reg[i+1] <= diff[i][W:0];
                    quo_reg[i+1] <= {quo_reg[i][W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= trial[i];
                    quo_reg[i+1] <= {quo_reg[i][W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        flags.active   = act_reg[S];
        flags.is_div   = div_reg[S];
        flags.div_zero = (dvs_reg[S] == '0);
        if (div_reg[S])
        begin
            high       = quo_reg[S];
            low        = rem_reg[S][W-1:0];
        end
        else
        begin
            high       = prod_reg[S][2*W-1:W];
            low        = prod_reg[S][W-1:0];
        end
        flags.zero     = (high == '0) && (low == '0);
    end
endmodule
`default_nettype wire

// ===== hdl/smdu_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Combine lane results into one item: masking, zero flag and fault suppression.
module smdu_merge
(
    input  wire smdu_pkg::word_t       high  [smdu_pkg::FieldLanes],
    input  wire smdu_pkg::word_t       low   [smdu_pkg::FieldLanes],
    input  wire smdu_pkg::lane_flags_t flags [smdu_pkg::FieldLanes],
    output smdu_pkg::out_item_t        item
);
    localparam int L = smdu_pkg::FieldLanes;
    smdu_pkg::word_t hi_m [L];
    smdu_pkg::word_t lo_m [L];
    logic            fault;
    logic            zero;

    always_comb
    begin
        fault = 1'b0;
        zero  = 1'b0;
        for (int i = 0; i < L; i++)
        begin
            if (flags[i].active && flags[i].is_div && flags[i].div_zero)
                fault = 1'b1;
            if (flags[i].active && flags[i].zero)
                zero = 1'b1;
        end
        for (int i = 0; i < L; i++)
        begin
            hi_m[i] = (flags[i].active && !fault) ? high[i] : '0;
            lo_m[i] = (flags[i].active && !fault) ? low[i] : '0;
        end
        item.high_0       = hi_m[0];
        item.high_1       = hi_m[1];
        item.high_2       = hi_m[2];
        item.high_3       = hi_m[3];
        item.low_0        = lo_m[0];
        item.low_1        = lo_m[1];
        item.low_2        = lo_m[2];
        item.low_3        = lo_m[3];
        item.zero_hit     = zero && !fault;
        item.divide_fault = fault;
    end
endmodule
`default_nettype wire

// ===== hdl/simd_mul_div_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                                   handshake
// in        in   func, vector_mode, left_0..3, right_0..3  valid/ready
// out       out  high_0..3, low_0..3, zero_hit, divide_fault valid/ready
// One item per cycle unless the output stalls. Stages: input register, 16
// divide step stages, output register. The divide step count sets the depth.
// The whole pipeline moves when the output register is free or being taken.
// Reset clears only valid bits. A stalled output freezes every stage.
module simd_mul_div_unit_top
#(
    parameter int LANES = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    smdu_in_if.sink       in_ch,
    smdu_out_if.source    out_ch
);
    localparam int L  = smdu_pkg::FieldLanes;
    localparam int S  = smdu_pkg::DivSteps;
    localparam int NL = (LANES > L) ? L : ((LANES < 1) ? 1 : LANES);

    logic [S:0]                 vld_reg;
    logic                       out_vld_reg;
    smdu_pkg::out_item_t        out_reg;
    logic                       advance;
    smdu_pkg::word_t            lefts  [L];
    smdu_pkg::word_t            rights [L];
    smdu_pkg::word_t            highs  [L];
    smdu_pkg::word_t            lows   [L];
    smdu_pkg::lane_flags_t      flags  [L];
    smdu_pkg::out_item_t        merged;

    assign advance      = !out_vld_reg || out_ch.ready;
    assign in_ch.ready  = advance;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.payload = out_reg;

    assign lefts[0]  = in_ch.payload.left_0;
    assign lefts[1]  = in_ch.payload.left_1;
    assign lefts[2]  = in_ch.payload.left_2;
    assign lefts[3]  = in_ch.payload.left_3;
    assign rights[0] = in_ch.payload.right_0;
    assign rights[1] = in_ch.payload.right_1;
    assign rights[2] = in_ch.payload.right_2;
    assign rights[3] = in_ch.payload.right_3;

    for (genvar g = 0; g < L; g++)
    begin : g_lane
        smdu_lane u_lane
        (
            .clk    (clk),
            .advance(advance),
            .active ((g == 0) || ((g < NL) && in_ch.payload.vector_mode[0])),
            .is_div (in_ch.payload.func == smdu_pkg::FUNC_DIV),
            .left   (lefts[g]),
            .right  (rights[g]),
            .high   (highs[g]),
            .low    (lows[g]),
            .flags  (flags[g])
        );
    end

    smdu_merge u_merge
    (
        .high (highs),
        .low  (lows),
        .flags(flags),
        .item (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[S-1:0], in_ch.valid};
            out_vld_reg <= vld_reg[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= merged;
    end
endmodule
`default_nettype wire

// ===== hdl/smdu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smdu_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire smdu_pkg::out_item_t out_payload
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("output item dropped or changed under stall");
    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.divide_fault[0] |->
            !out_payload.zero_hit[0] && out_payload.high_0 == '0
            && out_payload.low_0 == '0)
        else $error("fault item carries results");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");
endmodule

bind simd_mul_div_unit_top smdu_checker u_smdu_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_payload(out_ch.payload)
);
`default_nettype wire
